>>> rtl/core/lpht_pkg.sv
`default_nettype none
package lpht_pkg;

    localparam int KEY_W  = 64;
    localparam int PAY_W  = 64;
    localparam int LEN_W  = 4;

    localparam logic [1:0] OP_GET    = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;
    localparam logic [1:0] OP_DELETE = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_NO_SLOT   = 2'd2;
    localparam logic [1:0] ST_EXISTS    = 2'd3;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [KEY_W-1:0] key_bytes;
        logic [LEN_W-1:0] key_length;
        logic [PAY_W-1:0] payload_bytes;
        logic [LEN_W-1:0] payload_length;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [PAY_W-1:0] found_payload;
        logic [LEN_W-1:0] found_payload_length;
        logic [7:0]       slot_index;
    } rsp_t;

    // one slot of the store; free while key_len is zero
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] key_len;
        logic [PAY_W-1:0] pay;
        logic [LEN_W-1:0] pay_len;
    } slot_t;

endpackage
`default_nettype wire

>>> rtl/core/lpht_store.sv
`default_nettype none
module lpht_store #(
    parameter int SLOTS = 256,
    parameter int AW    = 8
) (
    input  wire logic            clk,
    input  wire logic            rd_en,
    input  wire logic [AW-1:0]   rd_addr,
    output lpht_pkg::slot_t      rd_data,
    input  wire logic            wr_en,
    input  wire logic [AW-1:0]   wr_addr,
    input  wire lpht_pkg::slot_t wr_data
);

    lpht_pkg::slot_t mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/lpht_ctrl.sv
`default_nettype none
module lpht_ctrl #(
    parameter int SLOTS         = 256,
    parameter int KEY_BYTES     = 8,
    parameter int PAYLOAD_BYTES = 8,
    parameter int AW            = 8,
    parameter int CW            = 9
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [8:0]      cap_in,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire lpht_pkg::req_t  in_data,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output lpht_pkg::rsp_t       out_data,
    output logic                 rd_en,
    output logic [AW-1:0]        rd_addr,
    input  wire lpht_pkg::slot_t rd_data,
    output logic                 wr_en,
    output logic [AW-1:0]        wr_addr,
    output lpht_pkg::slot_t      wr_data
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_HASH  = 6'b000100,
        S_MOD   = 6'b001000,
        S_PROBE = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    // key byte sum reaches 8*255, so at least 11 bits
    localparam int SW = (CW > 11) ? CW : 11;

    state_t           state_reg, state_next;
    logic [1:0]       op_reg;
    logic [63:0]      key_reg;
    logic [3:0]       klen_reg;
    logic [63:0]      pay_reg;
    logic [3:0]       plen_reg;
    logic [CW-1:0]    cap_reg;
    logic [SW-1:0]    sum_reg;
    logic [3:0]       bidx_reg;
    logic             bdone_reg;
    logic [CW-1:0]    slot_reg;
    logic             pend_reg;
    logic [CW-1:0]    count_reg;
    logic [AW:0]      clr_reg;
    logic             ovalid_reg;
    lpht_pkg::rsp_t   orsp_reg;

    logic [3:0]       klen_c, plen_c;
    logic [CW-1:0]    cap_c;
    logic [7:0]       cur_byte;
    logic             match, is_free, at_end;

    function automatic logic [63:0] bmask(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) < n)
            begin
                m[i*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    always_comb
    begin
        klen_c = in_data.key_length;
        if (klen_c == 4'd0)
        begin
            klen_c = 4'd1;
        end
        else if (klen_c > 4'(KEY_BYTES))
        begin
            klen_c = 4'(KEY_BYTES);
        end
        plen_c = in_data.payload_length;
        if (plen_c == 4'd0)
        begin
            plen_c = 4'd1;
        end
        else if (plen_c > 4'(PAYLOAD_BYTES))
        begin
            plen_c = 4'(PAYLOAD_BYTES);
        end
        if (cap_in == 9'd0)
        begin
            cap_c = CW'(1);
        end
        else if (int'(cap_in) > SLOTS)
        begin
            cap_c = CW'(SLOTS);
        end
        else
        begin
            cap_c = CW'(cap_in);
        end
    end

    assign cur_byte = key_reg[bidx_reg[2:0]*8 +: 8];
    assign match    = (rd_data.key_len == klen_reg) && (rd_data.key == key_reg);
    assign is_free  = (rd_data.key_len == 4'd0);
    assign at_end   = (slot_reg + CW'(1) >= cap_reg);

    assign in_stall  = (state_reg != S_IDLE) || ovalid_reg;
    assign out_valid = ovalid_reg;
    assign out_data  = orsp_reg;

    always_comb
    begin
        state_next = state_reg;
        rd_en      = 1'b0;
        rd_addr    = slot_reg[AW-1:0];
        wr_en      = 1'b0;
        wr_addr    = slot_reg[AW-1:0];
        wr_data    = rd_data;
        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg[AW-1:0];
                wr_data = '0;
                if (clr_reg == (AW+1)'(SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (bdone_reg || bidx_reg >= klen_reg || cur_byte == 8'd0)
                begin
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (sum_reg < SW'(cap_reg))
                begin
                    if (op_reg == lpht_pkg::OP_INSERT && count_reg >= cap_reg)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = sum_reg[AW-1:0];
                        state_next = S_PROBE;
                    end
                end
            end
            S_PROBE:
            begin
                if (pend_reg)
                begin
                    if (op_reg == lpht_pkg::OP_INSERT && is_free)
                    begin
                        wr_en   = 1'b1;
                        wr_data = '{key: key_reg, key_len: klen_reg,
                                    pay: pay_reg, pay_len: plen_reg};
                        state_next = S_OUT;
                    end
                    else if (match)
                    begin
                        state_next = S_OUT;
                        if (op_reg == lpht_pkg::OP_UPDATE)
                        begin
                            wr_en = 1'b1;
                            wr_data.pay     = pay_reg;
                            wr_data.pay_len = plen_reg;
                        end
                        else if (op_reg == lpht_pkg::OP_DELETE)
                        begin
                            wr_en   = 1'b1;
                            wr_data = '0;
                        end
                    end
                    else if (at_end)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(slot_reg + CW'(1));
                    end
                end
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            count_reg  <= '0;
            pend_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            bdone_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ovalid_reg && !out_stall)
            begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + (AW+1)'(1);
                end
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        op_reg    <= in_data.opcode;
                        klen_reg  <= klen_c;
                        key_reg   <= in_data.key_bytes & bmask(klen_c);
                        plen_reg  <= plen_c;
                        pay_reg   <= in_data.payload_bytes & bmask(plen_c);
                        cap_reg   <= cap_c;
                        sum_reg   <= '0;
                        bidx_reg  <= '0;
                        bdone_reg <= 1'b0;
                        orsp_reg  <= '0;
                    end
                end
                S_HASH:
                begin
                    // one key byte per cycle
                    if (!bdone_reg && bidx_reg < klen_reg && cur_byte != 8'd0)
                    begin
                        sum_reg  <= sum_reg + SW'(cur_byte);
                        bidx_reg <= bidx_reg + 4'd1;
                    end
                    else
                    begin
                        bdone_reg <= 1'b1;
                    end
                    orsp_reg.status <= (op_reg == lpht_pkg::OP_INSERT)
                        ? lpht_pkg::ST_NO_SLOT : lpht_pkg::ST_NOT_FOUND;
                end
                S_MOD:
                begin
                    // reduce by repeated subtract; sum is at most 8*255
                    if (sum_reg >= SW'(cap_reg))
                    begin
                        sum_reg <= sum_reg - SW'(cap_reg);
                    end
                    else
                    begin
                        slot_reg <= CW'(sum_reg);
                        pend_reg <= !(op_reg == lpht_pkg::OP_INSERT
                                      && count_reg >= cap_reg);
                    end
                end
                S_PROBE:
                begin
                    if (pend_reg)
                    begin
                        if (op_reg == lpht_pkg::OP_INSERT && is_free)
                        begin
                            orsp_reg.status     <= lpht_pkg::ST_OK;
                            orsp_reg.slot_index <= 8'(slot_reg);
                            count_reg           <= count_reg + CW'(1);
                            pend_reg            <= 1'b0;
                        end
                        else if (match)
                        begin
                            pend_reg <= 1'b0;
                            if (op_reg == lpht_pkg::OP_INSERT)
                            begin
                                orsp_reg.status <= lpht_pkg::ST_EXISTS;
                            end
                            else
                            begin
                                orsp_reg.status     <= lpht_pkg::ST_OK;
                                orsp_reg.slot_index <= 8'(slot_reg);
                                if (op_reg == lpht_pkg::OP_GET)
                                begin
                                    orsp_reg.found_payload        <= rd_data.pay;
                                    orsp_reg.found_payload_length <= rd_data.pay_len;
                                end
                                else if (op_reg == lpht_pkg::OP_DELETE
                                         && count_reg != '0)
                                begin
                                    count_reg <= count_reg - CW'(1);
                                end
                            end
                        end
                        else if (at_end)
                        begin
                            pend_reg <= 1'b0;
                        end
                        else
                        begin
                            slot_reg <= slot_reg + CW'(1);
                        end
                    end
                end
                S_OUT:
                begin
                    ovalid_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/linear_probe_hash_table_top.sv
`default_nettype none
// Key-value table with linear probing over a synchronous slot memory.
// Request channel: in_valid / in_stall carry a req_t transaction (opcode,
// key, payload). Response channel: out_valid / out_stall carry one rsp_t
// transaction per request. capacity_we / capacity_data write the capacity
// register; the user is to write it only while the block is idle, which
// the block itself does not enforce.
// Each request is accepted, then its key bytes are summed up to the key
// length or the first zero byte, the sum is reduced modulo the capacity by
// repeated subtraction, consecutive slots are probed through the memory
// read port from the hashed slot up to the capacity, and the result is
// presented; one request at a time.
// After reset the memory is swept clear, one slot per cycle, over all
// SLOTS slots; in_stall stays high meanwhile. While out_stall holds the
// response, in_stall stays high and no new request is taken.
module linear_probe_hash_table_top #(
    parameter int SLOTS         = 256,
    parameter int KEY_BYTES     = 8,
    parameter int PAYLOAD_BYTES = 8
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           capacity_we,
    input  wire logic [8:0]     capacity_data,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire lpht_pkg::req_t in_data,
    output logic                out_valid,
    input  wire logic           out_stall,
    output lpht_pkg::rsp_t      out_data
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = AW + 1;

    logic [8:0]      cap_reg;
    logic            rd_en, wr_en;
    logic [AW-1:0]   rd_addr, wr_addr;
    lpht_pkg::slot_t rd_data, wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= 9'(SLOTS);
        end
        else if (capacity_we)
        begin
            cap_reg <= capacity_data;
        end
    end

    lpht_ctrl #(
        .SLOTS(SLOTS), .KEY_BYTES(KEY_BYTES), .PAYLOAD_BYTES(PAYLOAD_BYTES),
        .AW(AW), .CW(CW)
    ) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .cap_in(cap_reg),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
    );

    lpht_store #(.SLOTS(SLOTS), .AW(AW)) u_store (
        .clk(clk),
        .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
    );

endmodule
`default_nettype wire
